/* rtl/asdz_pkg.sv */
// Shared widths, stage map, types and arithmetic step functions of the dead-zone scaler.
`default_nettype none

package asdz_pkg;

  // Fixed-point format of the results: 1 << FRAC_BITS is full scale
  localparam int FRAC_BITS = 14;
  localparam int QW        = FRAC_BITS + 1;   // ramp factor and quotient width
  localparam int AW        = 17;              // input magnitude and vector length width
  localparam int NW        = 2 * AW;          // sum of squares
  localparam int PW        = AW + QW;         // component times factor
  localparam int SQ_RW     = AW + 3;          // square root partial remainder
  localparam int OW        = 16;              // result field width
  localparam int OUT_MAX   = 32767;

  // Two dependent steps per register stage in the root and the dividers
  localparam int STEPS_PER_STAGE = 2;
  localparam int SQ_STEPS  = AW;
  localparam int SQ_STAGES = (SQ_STEPS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
  localparam int DV_STAGES = (QW + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

  // Global stage map
  localparam int ST_IN    = 0;
  localparam int ST_SQR   = 1;
  localparam int ST_SUM   = 2;
  localparam int ST_ROOT0 = 3;
  localparam int ST_RAMP  = ST_ROOT0 + SQ_STAGES;
  localparam int ST_RDIV0 = ST_RAMP + 1;
  localparam int ST_FRAC  = ST_RDIV0 + DV_STAGES;
  localparam int ST_PROD  = ST_FRAC + 1;
  localparam int ST_LDIV0 = ST_PROD + 1;
  localparam int ST_OUT   = ST_LDIV0 + DV_STAGES;
  localparam int NS       = ST_OUT + 1;

  // Configuration port
  localparam int CFG_IW = 4;
  localparam int CFG_DW = 16;

  typedef enum logic [CFG_IW-1:0] {
    REG_AXIS_DZ  = 4'd0,
    REG_AXIS_FS  = 4'd1,
    REG_STICK_DZ = 4'd2,
    REG_STICK_FS = 4'd3
  } cfg_reg_e;

  localparam logic [14:0] AXIS_DZ_RST  = 15'd250;
  localparam logic [15:0] AXIS_FS_RST  = 16'd30000;
  localparam logic [15:0] STICK_DZ_RST = 16'd8000;
  localparam logic [15:0] STICK_FS_RST = 16'd30000;

  // Per-item control and operands that travel alongside the datapath
  typedef struct packed {
    logic          stick;
    logic          neg_x;
    logic          neg_y;
    logic [AW-1:0] ax;
    logic [AW-1:0] ay;
    logic [AW-1:0] len;
    logic          zero;
    logic          sat;
    logic [QW-1:0] frac;
  } side_t;

  typedef struct packed {
    logic [SQ_RW-1:0] rem;
    logic [AW-1:0]    root;
  } sq_t;

  typedef struct packed {
    logic [AW-1:0] rem;
    logic [QW-1:0] quo;
  } dv_t;

  // One digit of the bitwise integer square root
  function automatic sq_t sq_step(sq_t s, logic [1:0] pair);
    logic [SQ_RW-1:0] r2;
    logic [SQ_RW-1:0] trial;
    sq_t              o;
    r2    = {s.rem[SQ_RW-3:0], pair};
    trial = SQ_RW'({s.root, 2'b01});
    if (r2 >= trial) begin
      o.rem  = r2 - trial;
      o.root = {s.root[AW-2:0], 1'b1};
    end else begin
      o.rem  = r2;
      o.root = {s.root[AW-2:0], 1'b0};
    end
    return o;
  endfunction

  // One quotient bit of restoring division
  function automatic dv_t dv_step(dv_t s, logic nb, logic [AW-1:0] den);
    logic [AW:0] r2;
    logic [AW:0] dif;
    dv_t         o;
    r2  = {s.rem, nb};
    dif = r2 - {1'b0, den};
    if (r2 >= {1'b0, den}) begin
      o.rem = dif[AW-1:0];
      o.quo = {s.quo[QW-2:0], 1'b1};
    end else begin
      o.rem = r2[AW-1:0];
      o.quo = {s.quo[QW-2:0], 1'b0};
    end
    return o;
  endfunction

  // Saturate a magnitude to the result field and apply the sign
  function automatic logic [OW-1:0] pack_out(logic [QW-1:0] mag, logic neg);
    logic [OW-1:0] m;
    if (32'(mag) > 32'(OUT_MAX)) begin
      m = OW'(OUT_MAX);
    end else begin
      m = OW'(mag);
    end
    return neg ? (~m + 1'b1) : m;
  endfunction

endpackage

`default_nettype wire

/* rtl/asdz_ifs.sv */
// Handshake channel interfaces: reading in, configuration writes, result out.
`default_nettype none

interface asdz_in_if;
  import asdz_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 func;
  logic signed [AW-1:0] axis_x;
  logic signed [AW-1:0] axis_y;
  modport source (output valid, func, axis_x, axis_y, input ready);
  modport sink   (input valid, func, axis_x, axis_y, output ready);
endinterface

interface asdz_cfg_if;
  import asdz_pkg::*;
  logic              valid;
  logic              ready;
  logic [CFG_IW-1:0] index;
  logic [CFG_DW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

interface asdz_out_if;
  import asdz_pkg::*;
  logic                 valid;
  logic                 ready;
  logic signed [OW-1:0] out_x;
  logic signed [OW-1:0] out_y;
  modport source (output valid, out_x, out_y, input ready);
  modport sink   (input valid, out_x, out_y, output ready);
endinterface

`default_nettype wire

/* rtl/asdz_sqrt.sv */
// Pipelined integer square root, up to two root bits per register stage.
`default_nettype none

module asdz_sqrt (
  input  logic                            clk_i,
  input  logic [asdz_pkg::SQ_STAGES-1:0]  en_i,
  input  logic [asdz_pkg::NW-1:0]         rad_i,
  output logic [asdz_pkg::AW-1:0]         root_o
);
  import asdz_pkg::*;

  sq_t           st_q  [SQ_STAGES];
  sq_t           st_d  [SQ_STAGES];
  logic [NW-1:0] rad_q [SQ_STAGES];
  logic [NW-1:0] rad_d [SQ_STAGES];

  // Each stage takes the previous stage's partial result and resolves up to two bits
  always_comb begin
    for (int s = 0; s < SQ_STAGES; s++) begin
      if (s == 0) begin
        rad_d[s] = rad_i;
        st_d[s]  = '0;
      end else begin
        rad_d[s] = rad_q[s-1];
        st_d[s]  = st_q[s-1];
      end
      for (int j = 0; j < STEPS_PER_STAGE; j++) begin
        if (s * STEPS_PER_STAGE + j < SQ_STEPS) begin
          st_d[s] = sq_step(st_d[s], rad_d[s][NW-1-2*(s*STEPS_PER_STAGE+j) -: 2]);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < SQ_STAGES; s++) begin
      if (en_i[s]) begin
        st_q[s]  <= st_d[s];
        rad_q[s] <= rad_d[s];
      end
    end
  end

  assign root_o = st_q[SQ_STAGES-1].root;

endmodule

`default_nettype wire

/* rtl/asdz_div.sv */
// Pipelined restoring divider, up to two quotient bits per register stage.
`default_nettype none

module asdz_div (
  input  logic                            clk_i,
  input  logic [asdz_pkg::DV_STAGES-1:0]  en_i,
  input  logic [asdz_pkg::AW-1:0]         rem_i,   // upper dividend, below den_i
  input  logic [asdz_pkg::QW-1:0]         low_i,   // lower dividend bits
  input  logic [asdz_pkg::AW-1:0]         den_i,
  output logic [asdz_pkg::QW-1:0]         quo_o
);
  import asdz_pkg::*;

  dv_t           st_q  [DV_STAGES];
  dv_t           st_d  [DV_STAGES];
  logic [QW-1:0] low_q [DV_STAGES];
  logic [QW-1:0] low_d [DV_STAGES];
  logic [AW-1:0] den_q [DV_STAGES];
  logic [AW-1:0] den_d [DV_STAGES];

  // Shift in one dividend bit per step, subtract where it fits
  always_comb begin
    for (int s = 0; s < DV_STAGES; s++) begin
      if (s == 0) begin
        st_d[s]  = '{rem: rem_i, quo: '0};
        low_d[s] = low_i;
        den_d[s] = den_i;
      end else begin
        st_d[s]  = st_q[s-1];
        low_d[s] = low_q[s-1];
        den_d[s] = den_q[s-1];
      end
      for (int j = 0; j < STEPS_PER_STAGE; j++) begin
        if (s * STEPS_PER_STAGE + j < QW) begin
          st_d[s] = dv_step(st_d[s], low_d[s][QW-1-(s*STEPS_PER_STAGE+j)], den_d[s]);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < DV_STAGES; s++) begin
      if (en_i[s]) begin
        st_q[s]  <= st_d[s];
        low_q[s] <= low_d[s];
        den_q[s] <= den_d[s];
      end
    end
  end

  assign quo_o = st_q[DV_STAGES-1].quo;

endmodule

`default_nettype wire

/* rtl/analog_stick_dead_zone_scaler.sv */
// Top level of the analog stick dead-zone scaler: stage control, operands, registers.
//
// Takes one reading per cycle unless the output holds the pipeline, and returns one
// Q2.14 result per reading, in order. func 0 scales axis_x linearly between the axis
// dead zone and full scale (out_y is zero); func 1 scales the (x, y) vector radially
// by its length floor(sqrt(x*x+y*y)). Every item passes 32 register stages: three
// input stages, nine square-root stages (two root bits each, one in the last), one
// ramp set-up stage, eight divider stages for the ramp factor, one factor stage, one
// multiply stage, eight divider stages for the components and the output register.
// Items enter back to back; a stage holds only while it and every stage after it
// are full and the result is not taken.
// Registers 0..3 are to be written through cfg_i only while the block is idle; the
// block itself does not enforce this. Indices beyond 3 are ignored.
`default_nettype none

module analog_stick_dead_zone_scaler (
  input  logic            clk_i,
  input  logic            rst_ni,
  asdz_in_if.sink         in_i,
  asdz_cfg_if.sink        cfg_i,
  asdz_out_if.source      out_o
);
  import asdz_pkg::*;

  localparam logic [QW-1:0] ONE = QW'(1) << FRAC_BITS;

  // Configuration registers
  logic [14:0] axis_dz_q;
  logic [15:0] axis_fs_q;
  logic [15:0] stick_dz_q;
  logic [15:0] stick_fs_q;

  // Stage control
  logic [NS-1:0] v_q;
  logic [NS-1:0] en;
  side_t         side_q [NS];
  side_t         side_d [NS];

  // Datapath registers
  logic [NW-1:0] sqx_q, sqy_q, rad_q;
  logic [AW-1:0] rem0_q, den_q;
  logic [PW-1:0] prod_x_q, prod_y_q;
  logic [OW-1:0] outx_q, outy_q;

  logic [AW-1:0] root, ax_in, ay_in, xu, yu;
  logic [QW-1:0] rquo, qx, qy;
  logic [AW-1:0] m, dz, fs, rem0_d, den_d;
  logic          ramp_zero, ramp_sat;
  side_t         in_side;

  // Configuration writes
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_dz_q  <= AXIS_DZ_RST;
      axis_fs_q  <= AXIS_FS_RST;
      stick_dz_q <= STICK_DZ_RST;
      stick_fs_q <= STICK_FS_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        REG_AXIS_DZ:  axis_dz_q  <= cfg_i.data[14:0];
        REG_AXIS_FS:  axis_fs_q  <= cfg_i.data;
        REG_STICK_DZ: stick_dz_q <= cfg_i.data;
        REG_STICK_FS: stick_fs_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // A stage moves unless it and every stage after it are full and the result waits
  for (genvar k = 0; k < NS; k++) begin : g_en
    assign en[k] = out_o.ready || !(&v_q[NS-1:k]);
  end

  assign in_i.ready = en[ST_IN];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[ST_IN]) begin
        v_q[ST_IN] <= in_i.valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // Input decode: signs and magnitudes
  assign xu    = in_i.axis_x;
  assign yu    = in_i.axis_y;
  assign ax_in = xu[AW-1] ? AW'(~xu + 1'b1) : xu;
  assign ay_in = yu[AW-1] ? AW'(~yu + 1'b1) : yu;

  always_comb begin
    in_side       = '0;
    in_side.stick = in_i.func;
    in_side.neg_x = xu[AW-1];
    in_side.neg_y = yu[AW-1];
    in_side.ax    = ax_in;
    in_side.ay    = ay_in;
  end

  // Ramp set-up: choose operands by mode, offsets from the dead zone
  always_comb begin
    m         = side_q[ST_RAMP-1].stick ? root : side_q[ST_RAMP-1].ax;
    dz        = side_q[ST_RAMP-1].stick ? AW'(stick_dz_q) : AW'(axis_dz_q);
    fs        = side_q[ST_RAMP-1].stick ? AW'(stick_fs_q) : AW'(axis_fs_q);
    rem0_d    = m - dz;
    den_d     = fs - dz;
    ramp_zero = (m <= dz);
    ramp_sat  = (fs <= dz) || (rem0_d >= den_d);
  end

  // Sideband per stage, updated where a stage produces a new field
  always_comb begin
    side_d[ST_IN] = in_side;
    for (int k = 1; k < NS; k++) begin
      side_d[k] = side_q[k-1];
      if (k == ST_RAMP) begin
        side_d[k].len  = root;
        side_d[k].zero = ramp_zero;
        side_d[k].sat  = ramp_sat;
      end
      if (k == ST_FRAC) begin
        if (side_q[k-1].zero) begin
          side_d[k].frac = '0;
        end else if (side_q[k-1].sat) begin
          side_d[k].frac = ONE;
        end else begin
          side_d[k].frac = {1'b0, rquo[QW-1:1]};
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NS; k++) begin
      if (en[k]) begin
        side_q[k] <= side_d[k];
      end
    end
  end

  // Squares and their sum, ramp operands and component products
  always_ff @(posedge clk_i) begin
    if (en[ST_SQR]) begin
      sqx_q <= {{AW{1'b0}}, side_q[ST_IN].ax} * {{AW{1'b0}}, side_q[ST_IN].ax};
      sqy_q <= {{AW{1'b0}}, side_q[ST_IN].ay} * {{AW{1'b0}}, side_q[ST_IN].ay};
    end
    if (en[ST_SUM]) begin
      rad_q <= sqx_q + sqy_q;
    end
    if (en[ST_RAMP]) begin
      rem0_q <= rem0_d;
      den_q  <= den_d;
    end
    if (en[ST_PROD]) begin
      prod_x_q <= {{QW{1'b0}}, side_q[ST_FRAC].ax} * {{AW{1'b0}}, side_q[ST_FRAC].frac};
      prod_y_q <= {{QW{1'b0}}, side_q[ST_FRAC].ay} * {{AW{1'b0}}, side_q[ST_FRAC].frac};
    end
  end

  asdz_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en[ST_ROOT0 +: SQ_STAGES]),
    .rad_i  (rad_q),
    .root_o (root)
  );

  // Ramp factor: ((m - dz) << QW) / (fs - dz), halved to FRAC_BITS later
  asdz_div u_ramp_div (
    .clk_i (clk_i),
    .en_i  (en[ST_RDIV0 +: DV_STAGES]),
    .rem_i (rem0_q),
    .low_i ('0),
    .den_i (den_q),
    .quo_o (rquo)
  );

  // Component lanes: component * factor / length
  asdz_div u_x_div (
    .clk_i (clk_i),
    .en_i  (en[ST_LDIV0 +: DV_STAGES]),
    .rem_i (prod_x_q[PW-1:QW]),
    .low_i (prod_x_q[QW-1:0]),
    .den_i (side_q[ST_PROD].len),
    .quo_o (qx)
  );

  asdz_div u_y_div (
    .clk_i (clk_i),
    .en_i  (en[ST_LDIV0 +: DV_STAGES]),
    .rem_i (prod_y_q[PW-1:QW]),
    .low_i (prod_y_q[QW-1:0]),
    .den_i (side_q[ST_PROD].len),
    .quo_o (qy)
  );

  // Output register: sign, saturation, zero inside the dead zone
  always_ff @(posedge clk_i) begin
    if (en[ST_OUT]) begin
      if (!side_q[ST_OUT-1].stick) begin
        outx_q <= pack_out(side_q[ST_OUT-1].frac, side_q[ST_OUT-1].neg_x);
        outy_q <= '0;
      end else if (side_q[ST_OUT-1].zero) begin
        outx_q <= '0;
        outy_q <= '0;
      end else begin
        outx_q <= pack_out(qx, side_q[ST_OUT-1].neg_x);
        outy_q <= pack_out(qy, side_q[ST_OUT-1].neg_y);
      end
    end
  end

  assign out_o.valid = v_q[ST_OUT];
  assign out_o.out_x = outx_q;
  assign out_o.out_y = outy_q;

  // Checks
  a_ready_when_out_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_o.valid |-> in_i.ready)
    else $error("input stalled with an empty output stage");

  a_axis_y_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !side_q[ST_OUT].stick |-> out_o.out_y == '0)
    else $error("single-axis item with non-zero out_y");

  a_dead_zone_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && side_q[ST_OUT].zero |-> out_o.out_x == '0 && out_o.out_y == '0)
    else $error("item inside the dead zone gave a non-zero result");

  a_x_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> ($signed(out_o.out_x) <= $signed(32'(ONE)) &&
                     $signed(out_o.out_x) >= -$signed(32'(ONE))))
    else $error("out_x beyond full scale");

endmodule

`default_nettype wire

/* tb/sv/asdz_tb_ifs.sv */
// Testbench item types: one reading and one scaled result.
`default_nettype none

package asdz_tb_types;
  import asdz_pkg::*;

  // One reading as the testbench keeps it
  typedef struct packed {
    logic                 func;
    logic signed [AW-1:0] axis_x;
    logic signed [AW-1:0] axis_y;
  } reading_t;

  // One scaled result
  typedef struct packed {
    logic signed [OW-1:0] out_x;
    logic signed [OW-1:0] out_y;
  } scaled_t;
endpackage

`default_nettype wire

/* tb/sv/analog_stick_dead_zone_scaler_tb.sv */
// Self-checking testbench of the dead-zone scaler: directed and random readings, predicted results.
`default_nettype none

// Holds the register copy, predicts each result and checks results in order
class dz_scoreboard;
  logic [14:0] axis_dz;
  logic [15:0] axis_fs;
  logic [15:0] stick_dz;
  logic [15:0] stick_fs;
  asdz_tb_types::scaled_t pending[$];
  int errors;
  int checked;

  function new();
    axis_dz  = 15'd250;
    axis_fs  = 16'd30000;
    stick_dz = 16'd8000;
    stick_fs = 16'd30000;
    errors   = 0;
    checked  = 0;
  endfunction

  function void write_reg(asdz_pkg::cfg_reg_e idx, logic [15:0] val);
    case (idx)
      asdz_pkg::REG_AXIS_DZ:  axis_dz  = val[14:0];
      asdz_pkg::REG_AXIS_FS:  axis_fs  = val;
      asdz_pkg::REG_STICK_DZ: stick_dz = val;
      asdz_pkg::REG_STICK_FS: stick_fs = val;
      default: ;
    endcase
  endfunction

  // How far m lies between dz and full, in Q14
  function longint unsigned ramp_frac(longint unsigned m, longint unsigned dz,
                                      longint unsigned full);
    longint unsigned one;
    longint unsigned f;
    one = 64'd1 << asdz_pkg::FRAC_BITS;
    if (m <= dz) return 0;
    if (full <= dz) return one;
    f = ((m - dz) << asdz_pkg::FRAC_BITS) / (full - dz);
    return (f > one) ? one : f;
  endfunction

  function logic [15:0] signed_field(longint unsigned mag, bit neg);
    logic [15:0] m;
    m = (mag > 32767) ? 16'd32767 : mag[15:0];
    return neg ? -m : m;
  endfunction

  function longint unsigned int_root(longint unsigned n);
    longint unsigned r;
    r = 0;
    for (int b = 17; b >= 0; b--)
      if ((r + (64'd1 << b)) * (r + (64'd1 << b)) <= n) r = r + (64'd1 << b);
    return r;
  endfunction

  // Note an accepted reading and queue its expected result
  function void note_reading(asdz_tb_types::reading_t rd);
    asdz_tb_types::scaled_t res;
    longint signed x, y;
    longint unsigned ax, ay, len, f;
    x  = rd.axis_x;
    y  = rd.axis_y;
    ax = (x < 0) ? -x : x;
    ay = (y < 0) ? -y : y;
    res = '0;
    if (!rd.func) begin
      res.out_x = signed_field(ramp_frac(ax, axis_dz, axis_fs), x < 0);
    end else begin
      len = int_root(ax * ax + ay * ay);
      if (!(len < stick_dz || len == 0)) begin
        f = ramp_frac(len, stick_dz, stick_fs);
        res.out_x = signed_field((ax * f) / len, x < 0);
        res.out_y = signed_field((ay * f) / len, y < 0);
      end
    end
    pending = {pending, res};
  endfunction

  function void check_result(asdz_tb_types::scaled_t got);
    asdz_tb_types::scaled_t exp_res;
    checked++;
    if (pending.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result x=%0d y=%0d", got.out_x, got.out_y);
      return;
    end
    exp_res = pending.pop_front();
    if (got.out_x !== exp_res.out_x || got.out_y !== exp_res.out_y) begin
      errors++;
      if (errors <= 10)
        $display("mismatch: expected x=%0d y=%0d, got x=%0d y=%0d",
                 exp_res.out_x, exp_res.out_y, got.out_x, got.out_y);
    end
  endfunction
endclass

module analog_stick_dead_zone_scaler_tb;
  import asdz_pkg::*;
  import asdz_tb_types::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 40;

  logic clk_i;
  logic rst_ni;
  asdz_in_if  in_ch ();
  asdz_cfg_if cfg_ch ();
  asdz_out_if out_ch ();

  dz_scoreboard sb;
  bit quiet;        // no idling in the closing stretch
  bit long_hold;    // receiver holds off for a long stretch
  int sent;

  analog_stick_dead_zone_scaler dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch.sink),
    .cfg_i  (cfg_ch.sink),
    .out_o  (out_ch.source)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watch both handshakes at the edge
  always @(posedge clk_i) begin
    if (rst_ni && in_ch.valid && in_ch.ready)
      sb.note_reading('{in_ch.func, in_ch.axis_x, in_ch.axis_y});
    if (rst_ni && out_ch.valid && out_ch.ready)
      sb.check_result('{out_ch.out_x, out_ch.out_y});
  end

  // Receiver: random stall bursts, a long hold on request
  initial begin
    int n;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (long_hold) begin
        out_ch.ready <= 1'b0;
        repeat (200) @(posedge clk_i);
        long_hold = 0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 8);
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  task automatic send_reading(logic fn, logic signed [AW-1:0] x, logic signed [AW-1:0] y);
    int n;
    if (!quiet && $urandom_range(0, 6) == 0) begin
      n = $urandom_range(1, 8);
      in_ch.valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    in_ch.valid  <= 1'b1;
    in_ch.func   <= fn;
    in_ch.axis_x <= x;
    in_ch.axis_y <= y;
    do @(posedge clk_i); while (!in_ch.ready);
    sent++;
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (LATENCY) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [15:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  task automatic configure(logic [14:0] adz, logic [15:0] afs, logic [15:0] sdz,
                           logic [15:0] sfs);
    write_reg(REG_AXIS_DZ, {1'b0, adz});
    write_reg(REG_AXIS_FS, afs);
    write_reg(REG_STICK_DZ, sdz);
    write_reg(REG_STICK_FS, sfs);
  endtask

  // Random reading, often near the extremes or the dead zones
  function automatic logic signed [AW-1:0] rand_axis();
    case ($urandom_range(0, 5))
      0: return 17'sd32768;
      1: return -17'sd32768;
      2: return AW'($urandom_range(0, 600) - 300);
      default: return AW'($urandom_range(0, 65536) - 32768);
    endcase
  endfunction

  task automatic random_block(int cnt);
    for (int i = 0; i < cnt; i++)
      send_reading(1'($urandom_range(0, 1)), rand_axis(), rand_axis());
  endtask

  initial begin
    sb = new();
    quiet = 0;
    long_hold = 0;
    sent = 0;
    rst_ni = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.func = 1'b0;
    in_ch.axis_x = '0;
    in_ch.axis_y = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_AXIS_DZ;
    cfg_ch.data = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset settings, extremes, dead-zone edges, zero reading
    send_reading(1'b0, 17'sd0, 17'sd0);
    send_reading(1'b0, 17'sd250, -17'sd32768);
    send_reading(1'b0, -17'sd251, 17'sd5);
    send_reading(1'b0, 17'sd32768, 17'sd0);
    send_reading(1'b0, -17'sd32768, 17'sd0);
    send_reading(1'b0, 17'sd30000, 17'sd0);
    send_reading(1'b1, 17'sd8000, 17'sd0);
    send_reading(1'b1, 17'sd7999, 17'sd0);
    send_reading(1'b1, 17'sd32768, 17'sd32768);
    send_reading(1'b1, -17'sd32768, -17'sd32768);
    send_reading(1'b1, -17'sd20000, 17'sd15000);
    send_reading(1'b1, 17'sd0, -17'sd32768);
    wait_drained();

    // Zero dead zones with a zero vector and small lengths
    configure(15'd0, 16'd1, 16'd0, 16'd1);
    send_reading(1'b1, 17'sd0, 17'sd0);
    send_reading(1'b1, 17'sd1, -17'sd1);
    send_reading(1'b0, 17'sd0, 17'sd0);
    send_reading(1'b0, -17'sd1, 17'sd0);
    random_block(40);
    wait_drained();

    // Full scale barely above, equal to, then below the dead zone
    configure(15'd32767, 16'd32768, 16'd46341, 16'd46341);
    send_reading(1'b0, 17'sd32767, 17'sd0);
    send_reading(1'b0, -17'sd32768, 17'sd0);
    send_reading(1'b1, 17'sd32768, 17'sd32768);
    send_reading(1'b1, 17'sd32768, 17'sd32767);
    random_block(40);
    wait_drained();
    configure(15'd1000, 16'd500, 16'd20000, 16'd100);
    send_reading(1'b1, 17'sd20000, 17'sd0);
    random_block(60);

    // Long receiver stall while readings keep coming
    long_hold = 1;
    random_block(80);
    wait_drained();

    // Several random settings
    for (int k = 0; k < 4; k++) begin
      configure(15'($urandom_range(0, 32767)), 16'($urandom_range(1, 32768)),
                16'($urandom_range(0, 46341)), 16'($urandom_range(1, 46341)));
      random_block(80);
      wait_drained();
    end
    configure(15'd250, 16'd30000, 16'd8000, 16'd30000);
    random_block(60);
    quiet = 1;
    random_block(60);
    wait_drained();

    $display("Sent %0d readings over nine register settings with a long output stall,",
             sent);
    $display("%0d results checked.", sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches, %0d results outstanding", sb.errors, sb.pending.size());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Timeout");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

`default_nettype wire

/* files.f */
rtl/asdz_pkg.sv
rtl/asdz_ifs.sv
rtl/asdz_sqrt.sv
rtl/asdz_div.sv
rtl/analog_stick_dead_zone_scaler.sv
tb/sv/asdz_tb_ifs.sv
tb/sv/analog_stick_dead_zone_scaler_tb.sv
